/* hw/rtl/rtphp_pkg.sv */
// Shared types and constants for the RTP header payload locator.
// Used by the channel interfaces, the tracker, the checker and the top level.
`timescale 1ns / 1ps
`default_nettype none

package rtphp_pkg;

  localparam int BYTE_W  = 8;
  localparam int POS_W   = 12;
  localparam int EXT_W   = 16;
  localparam int CAUSE_W = 3;

  localparam logic [POS_W-1:0] MAX_PACKET_BYTES = 12'd2048;
  localparam logic [POS_W-1:0] HDR_FIXED_BYTES  = 12'd12;
  localparam logic [POS_W-1:0] EXT_HDR_BYTES    = 12'd4;
  localparam logic [1:0]       RTP_VERSION      = 2'd2;

  typedef enum logic [CAUSE_W-1:0] {
    CAUSE_OK       = 3'd0,
    CAUSE_SHORT    = 3'd1,
    CAUSE_CSRC     = 3'd2,
    CAUSE_EXT      = 3'd3,
    CAUSE_PAD      = 3'd4,
    CAUSE_OVERSIZE = 3'd5
  } cause_t;

  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [BYTE_W-1:0] hdr;
    logic [EXT_W-1:0]  ext;
    logic              oversize;
  } pkt_state_t;

  typedef struct packed {
    logic             header_ok;
    cause_t           cause;
    logic [POS_W-1:0] start;
    logic [POS_W-1:0] bytes;
  } result_t;

endpackage

`default_nettype wire

/* hw/rtl/rtphp_in_if.sv */
// Byte request channel: one packet byte plus its last-byte mark.
// Depends on rtphp_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

interface rtphp_in_if;
  import rtphp_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              end_of_packet;

  modport source (output valid, output data_byte, output end_of_packet, input ready);
  modport sink   (input valid, input data_byte, input end_of_packet, output ready);

endinterface

`default_nettype wire

/* hw/rtl/rtphp_out_if.sv */
// Result request channel: header verdict, cause code and payload location.
// Depends on rtphp_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

interface rtphp_out_if;
  import rtphp_pkg::*;

  logic               valid;
  logic               ready;
  logic               header_ok;
  logic [CAUSE_W-1:0] error_cause;
  logic [POS_W-1:0]   payload_start;
  logic [POS_W-1:0]   payload_bytes;

  modport source (output valid, output header_ok, output error_cause,
                  output payload_start, output payload_bytes, input ready);
  modport sink   (input valid, input header_ok, input error_cause,
                  input payload_start, input payload_bytes, output ready);

endinterface

`default_nettype wire

/* hw/rtl/rtphp_track.sv */
// Per-packet state: byte count, first header byte, extension length, oversize flag.
// Depends on rtphp_pkg; gives the state as updated by the current byte.
`timescale 1ns / 1ps
`default_nettype none

module rtphp_track (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       step,
  input  wire logic [rtphp_pkg::BYTE_W-1:0] data_byte,
  input  wire logic                       last,
  output rtphp_pkg::pkt_state_t           upd
);
  import rtphp_pkg::*;

  logic [POS_W-1:0]  byte_position;
  logic [BYTE_W-1:0] first_header_byte;
  logic [EXT_W-1:0]  extension_word_count;
  logic              oversize_seen;
  logic [POS_W-1:0]  ext_at;

  always_comb begin
    upd.pos      = byte_position;
    upd.hdr      = first_header_byte;
    upd.ext      = extension_word_count;
    upd.oversize = oversize_seen;
    ext_at       = '0;
    if (byte_position >= MAX_PACKET_BYTES) begin
      upd.oversize = 1'b1;
    end else begin
      if (byte_position == '0) begin
        upd.hdr = data_byte;
      end
      ext_at = HDR_FIXED_BYTES + {{(POS_W-6){1'b0}}, upd.hdr[3:0], 2'b00};
      if (byte_position == ext_at + 12'd2) begin
        upd.ext = {data_byte, extension_word_count[BYTE_W-1:0]};
      end else if (byte_position == ext_at + 12'd3) begin
        upd.ext = {extension_word_count[EXT_W-1:BYTE_W], data_byte};
      end
      upd.pos = byte_position + 12'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position        <= '0;
      first_header_byte    <= '0;
      extension_word_count <= '0;
      oversize_seen        <= 1'b0;
    end else if (step) begin
      if (last) begin
        byte_position        <= '0;
        first_header_byte    <= '0;
        extension_word_count <= '0;
        oversize_seen        <= 1'b0;
      end else begin
        byte_position        <= upd.pos;
        first_header_byte    <= upd.hdr;
        extension_word_count <= upd.ext;
        oversize_seen        <= upd.oversize;
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/rtphp_check.sv */
// Header checks at the last byte: oversize, version/length, CSRC, extension, padding.
// Depends on rtphp_pkg; pure logic from the updated packet state.
`timescale 1ns / 1ps
`default_nettype none

module rtphp_check (
  input  wire rtphp_pkg::pkt_state_t        st,
  input  wire logic [rtphp_pkg::BYTE_W-1:0] pad_byte,
  output rtphp_pkg::result_t                res
);
  import rtphp_pkg::*;

  logic [POS_W-1:0] csrc_end;
  logic [POS_W-1:0] csrc_room;
  logic [POS_W-1:0] ext_room;
  logic             ext_fail;
  logic [POS_W-1:0] ext_end;
  logic [POS_W-1:0] hdr_end;
  logic [POS_W-1:0] pad_room;
  logic [POS_W-1:0] pad_ext;
  logic             pad_fail;
  logic [POS_W-1:0] payload_end;

  always_comb begin
    csrc_end  = HDR_FIXED_BYTES + {{(POS_W-6){1'b0}}, st.hdr[3:0], 2'b00};
    csrc_room = st.pos - csrc_end;
    ext_room  = csrc_room - EXT_HDR_BYTES;
    ext_fail  = (csrc_room < EXT_HDR_BYTES) ||
                (st.ext > {{(EXT_W-POS_W+2){1'b0}}, ext_room[POS_W-1:2]});
    ext_end   = csrc_end + EXT_HDR_BYTES + {st.ext[POS_W-3:0], 2'b00};
    hdr_end   = st.hdr[4] ? ext_end : csrc_end;
    pad_room  = st.pos - hdr_end;
    pad_ext   = {{(POS_W-BYTE_W){1'b0}}, pad_byte};
    pad_fail  = (pad_byte == '0) || (pad_ext > pad_room);
    payload_end = st.hdr[5] ? (st.pos - pad_ext) : st.pos;

    res.header_ok = 1'b0;
    res.start     = '0;
    res.bytes     = '0;
    if (st.oversize) begin
      res.cause = CAUSE_OVERSIZE;
    end else if ((st.pos < HDR_FIXED_BYTES) || (st.hdr[7:6] != RTP_VERSION)) begin
      res.cause = CAUSE_SHORT;
    end else if (csrc_end > st.pos) begin
      res.cause = CAUSE_CSRC;
    end else if (st.hdr[4] && ext_fail) begin
      res.cause = CAUSE_EXT;
    end else if (st.hdr[5] && pad_fail) begin
      res.cause = CAUSE_PAD;
    end else begin
      res.cause     = CAUSE_OK;
      res.header_ok = 1'b1;
      res.start     = hdr_end;
      res.bytes     = payload_end - hdr_end;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/rtp_header_payload_locator_top.sv */
// Top level of the RTP header payload locator: input register, tracker, checker,
// result register. Depends on rtphp_pkg, rtphp_in_if, rtphp_out_if, rtphp_track, rtphp_check.
//
//  channel  | dir | payload
//  ---------+-----+-----------------------------------------------------------
//  pkt_in   | in  | data_byte[7:0], end_of_packet
//  res_out  | out | header_ok, error_cause[2:0], payload_start[11:0], payload_bytes[11:0]
//
// One byte per cycle sustained, except while a last byte waits on an untaken result;
// a result enters the result register as its last byte leaves the input register. The rate
// is set by the combinational state update between the input and result registers.
// Reset (rst, synchronous) clears the packet state and both valid flags.
// A last byte waits in the input register while an untaken result is held;
// other bytes pass on regardless of res_out.ready.
`timescale 1ns / 1ps
`default_nettype none

module rtp_header_payload_locator_top (
  input wire logic    clk,
  input wire logic    rst,
  rtphp_in_if.sink    pkt_in,
  rtphp_out_if.source res_out
);
  import rtphp_pkg::*;

  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              in_last;
  logic              proc_fire;
  pkt_state_t        upd;
  result_t           res;
  logic              out_valid;
  result_t           out_res;

  assign proc_fire    = in_valid && (!in_last || !out_valid || res_out.ready);
  assign pkt_in.ready = !in_valid || proc_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (pkt_in.valid && pkt_in.ready) begin
      in_valid <= 1'b1;
    end else if (proc_fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pkt_in.valid && pkt_in.ready) begin
      in_byte <= pkt_in.data_byte;
      in_last <= pkt_in.end_of_packet;
    end
  end

  rtphp_track u_track (
    .clk       (clk),
    .rst       (rst),
    .step      (proc_fire),
    .data_byte (in_byte),
    .last      (in_last),
    .upd       (upd)
  );

  rtphp_check u_check (
    .st       (upd),
    .pad_byte (in_byte),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc_fire && in_last) begin
      out_valid <= 1'b1;
    end else if (res_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire && in_last) begin
      out_res <= res;
    end
  end

  assign res_out.valid         = out_valid;
  assign res_out.header_ok     = out_res.header_ok;
  assign res_out.error_cause   = out_res.cause;
  assign res_out.payload_start = out_res.start;
  assign res_out.payload_bytes = out_res.bytes;

  a_ok_matches_cause: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_res.header_ok == (out_res.cause == CAUSE_OK)))
    else $error("header_ok disagrees with error_cause");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_res.header_ok) |-> (out_res.start == '0 && out_res.bytes == '0))
    else $error("error result carries a payload location");

  a_payload_fits: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.header_ok) |->
      (({1'b0, out_res.start} + {1'b0, out_res.bytes}) <= {1'b0, MAX_PACKET_BYTES}))
    else $error("payload runs past the maximum packet size");

  a_start_past_fixed: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.header_ok) |-> (out_res.start >= HDR_FIXED_BYTES))
    else $error("payload starts inside the fixed header");

endmodule

`default_nettype wire

/* bench/rtp_header_payload_locator_top_tb.sv */
// Self-checking bench for rtp_header_payload_locator_top: directed packet table, then
// random RTP packets, with random gaps on both channels and an in-bench payload locator.
// Depends on rtphp_pkg, rtphp_in_if, rtphp_out_if and the locator RTL.
`timescale 1ns / 1ps

module rtp_header_payload_locator_top_tb;
  import rtphp_pkg::*;

  localparam int IDLE_LIMIT   = 1500;
  localparam int RANDOM_BYTES = 1000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct {
    logic [BYTE_W-1:0] hdr;
    int                len;
    logic [EXT_W-1:0]  ext;
    logic [BYTE_W-1:0] pad;
    bit                typed;
    cause_t            cause;
    int                start;
    int                nbytes;
  } pkt_row_t;

  // Typed rows carry the result read straight off the header rules; others use the locator.
  pkt_row_t directed_rows [23] = '{
    '{8'h80,   12, 16'h0000, 8'h00, 1'b1, CAUSE_OK,        12,    0},
    '{8'h80,    1, 16'h0000, 8'h00, 1'b1, CAUSE_SHORT,      0,    0},
    '{8'h80,   11, 16'h0000, 8'h00, 1'b1, CAUSE_SHORT,      0,    0},
    '{8'h40,   20, 16'h0000, 8'h00, 1'b1, CAUSE_SHORT,      0,    0},
    '{8'hC0,   20, 16'h0000, 8'h00, 1'b1, CAUSE_SHORT,      0,    0},
    '{8'h00,   12, 16'h0000, 8'h00, 1'b1, CAUSE_SHORT,      0,    0},
    '{8'h8F,   71, 16'h0000, 8'h00, 1'b1, CAUSE_CSRC,       0,    0},
    '{8'h8F,   72, 16'h0000, 8'h00, 1'b1, CAUSE_OK,        72,    0},
    '{8'h90,   15, 16'h0000, 8'h00, 1'b1, CAUSE_EXT,        0,    0},
    '{8'h90,   16, 16'h0000, 8'h00, 1'b1, CAUSE_OK,        16,    0},
    '{8'h90,   20, 16'h0002, 8'h00, 1'b1, CAUSE_EXT,        0,    0},
    '{8'h90,   24, 16'h0002, 8'h00, 1'b1, CAUSE_OK,        24,    0},
    '{8'h90,  100, 16'hFFFF, 8'h00, 1'b1, CAUSE_EXT,        0,    0},
    '{8'hA0,   20, 16'h0000, 8'h00, 1'b1, CAUSE_PAD,        0,    0},
    '{8'hA0,   20, 16'h0000, 8'h09, 1'b1, CAUSE_PAD,        0,    0},
    '{8'hA0,   20, 16'h0000, 8'h08, 1'b1, CAUSE_OK,        12,    0},
    '{8'hA0,   20, 16'h0000, 8'hFF, 1'b1, CAUSE_PAD,        0,    0},
    '{8'hA0,   40, 16'h0000, 8'h03, 1'b1, CAUSE_OK,        12,   25},
    '{8'hBF,  100, 16'h0002, 8'h04, 1'b0, CAUSE_OK,         0,    0},
    '{8'h80,   30, 16'hFFFF, 8'hAA, 1'b0, CAUSE_OK,         0,    0},
    '{8'hFF,   40, 16'h0000, 8'h00, 1'b1, CAUSE_SHORT,      0,    0},
    '{8'hB5,   60, 16'h0001, 8'h07, 1'b0, CAUSE_OK,         0,    0},
    '{8'h00, 2049, 16'h0000, 8'h00, 1'b1, CAUSE_OVERSIZE,   0,    0}
  };

  logic clk;
  logic rst = 1'b1;
  logic sink_ready = 1'b0;

  rtphp_in_if  pkt_in_if ();
  rtphp_out_if res_out_if ();

  assign res_out_if.ready = sink_ready;

  rtp_header_payload_locator_top uut (
    .clk     (clk),
    .rst     (rst),
    .pkt_in  (pkt_in_if),
    .res_out (res_out_if)
  );

  logic [POS_W-1:0]  trk_pos  = '0;
  logic [BYTE_W-1:0] trk_hdr  = '0;
  logic [EXT_W-1:0]  trk_ext  = '0;
  logic              trk_over = 1'b0;

  result_t pending_results [$];
  bit      pinned_valid = 1'b0;
  result_t pinned_res;
  int      mismatch_count = 0;
  int      results_seen = 0;
  int      idle_cycles = 0;
  int      stall_left = 0;
  int      phase_left = 0;
  bit      calm = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic bit locate_payload(input logic [BYTE_W-1:0] b, input bit last,
                                        output result_t res);
    int     ext_at;
    int     len;
    int     start;
    int     fin;
    cause_t cause;
    res = '0;
    if (int'(trk_pos) >= int'(MAX_PACKET_BYTES)) begin
      trk_over = 1'b1;
    end else begin
      if (trk_pos == '0) trk_hdr = b;
      ext_at = int'(HDR_FIXED_BYTES) + int'(trk_hdr[3:0]) * 4;
      if (int'(trk_pos) == ext_at + 2) trk_ext[15:8] = b;
      else if (int'(trk_pos) == ext_at + 3) trk_ext[7:0] = b;
      trk_pos = trk_pos + 1'b1;
    end
    if (!last) return 1'b0;
    len = int'(trk_pos);
    fin = len;
    cause = CAUSE_OK;
    start = int'(HDR_FIXED_BYTES) + int'(trk_hdr[3:0]) * 4;
    if (trk_over) begin
      cause = CAUSE_OVERSIZE;
    end else if (len < int'(HDR_FIXED_BYTES) || trk_hdr[7:6] != RTP_VERSION) begin
      cause = CAUSE_SHORT;
    end else if (start > len) begin
      cause = CAUSE_CSRC;
    end else begin
      if (trk_hdr[4]) begin
        if (len - start < int'(EXT_HDR_BYTES) ||
            int'(trk_ext) > (len - start - int'(EXT_HDR_BYTES)) / 4) begin
          cause = CAUSE_EXT;
        end else begin
          start = start + int'(EXT_HDR_BYTES) + int'(trk_ext) * 4;
        end
      end
      if (cause == CAUSE_OK && trk_hdr[5]) begin
        if (b == '0 || int'(b) > len - start) cause = CAUSE_PAD;
        else fin = fin - int'(b);
      end
    end
    res.header_ok = (cause == CAUSE_OK);
    res.cause = cause;
    if (cause == CAUSE_OK) begin
      res.start = start[POS_W-1:0];
      res.bytes = fin[POS_W-1:0] - start[POS_W-1:0];
    end
    trk_pos = '0;
    trk_hdr = '0;
    trk_ext = '0;
    trk_over = 1'b0;
    return 1'b1;
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    $display("%0t: result %0d %s: got %0d, expected %0d", $time, results_seen, what, got, want);
  endtask

  task automatic push_byte(input logic [BYTE_W-1:0] b, input bit last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      pkt_in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pkt_in_if.valid <= 1'b1;
    pkt_in_if.data_byte <= b;
    pkt_in_if.end_of_packet <= last;
    @(posedge clk);
    while (!(pkt_in_if.valid && pkt_in_if.ready)) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_packet(input pkt_row_t row);
    logic [BYTE_W-1:0] pkt [];
    int                ext_at;
    pkt = new[row.len];
    foreach (pkt[i]) pkt[i] = BYTE_W'($urandom_range(0, 255));
    pkt[row.len-1] = row.pad;
    ext_at = int'(HDR_FIXED_BYTES) + int'(row.hdr[3:0]) * 4;
    if (ext_at + 2 < row.len) pkt[ext_at+2] = row.ext[15:8];
    if (ext_at + 3 < row.len) pkt[ext_at+3] = row.ext[7:0];
    pkt[0] = row.hdr;
    pinned_valid = row.typed;
    pinned_res.header_ok = (row.cause == CAUSE_OK);
    pinned_res.cause = row.cause;
    pinned_res.start = row.start[POS_W-1:0];
    pinned_res.bytes = row.nbytes[POS_W-1:0];
    foreach (pkt[i]) push_byte(pkt[i], i == row.len - 1);
  endtask

  task automatic hold_until_drained();
    pkt_in_if.valid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  task automatic send_random_packets();
    pkt_row_t row;
    int       sent;
    int       cc;
    int       ew;
    int       padn;
    bit       x;
    bit       p;
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      row = '{cause: CAUSE_OK, default: 0};
      if ($urandom_range(0, 3) != 0) begin
        cc = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 2);
        x = $urandom_range(0, 1);
        p = $urandom_range(0, 1);
        ew = x ? $urandom_range(0, 3) : 0;
        padn = p ? $urandom_range(1, 16) : 0;
        row.hdr = {RTP_VERSION, p, x, cc[3:0]};
        row.ext = x ? EXT_W'(ew) : EXT_W'($urandom_range(0, 65535));
        row.len = int'(HDR_FIXED_BYTES) + 4 * cc + (x ? int'(EXT_HDR_BYTES) + 4 * ew : 0)
                  + $urandom_range(0, 24) + padn;
        row.pad = p ? BYTE_W'(padn) : BYTE_W'($urandom_range(0, 255));
      end else begin
        row.hdr = BYTE_W'($urandom_range(0, 255));
        if ($urandom_range(0, 1) != 0) row.hdr[7:6] = RTP_VERSION;
        row.len = $urandom_range(1, 64);
        row.ext = ($urandom_range(0, 1) != 0) ? EXT_W'($urandom_range(0, 24))
                                              : EXT_W'($urandom_range(0, 65535));
        row.pad = BYTE_W'($urandom_range(0, 255));
      end
      send_packet(row);
      sent += row.len;
    end
  endtask

  always @(negedge clk) begin
    if (phase_left == 0) begin
      calm = !calm;
      phase_left = $urandom_range(30, 300);
    end else begin
      phase_left--;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      sink_ready <= 1'b0;
    end else if (stall_left > 0) begin
      sink_ready <= 1'b0;
      stall_left--;
    end else begin
      sink_ready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    result_t res;
    result_t want;
    bit      in_acc;
    bit      out_acc;
    if (!rst) begin
      in_acc = pkt_in_if.valid && pkt_in_if.ready;
      out_acc = res_out_if.valid && res_out_if.ready;
      if (in_acc) begin
        if (locate_payload(pkt_in_if.data_byte, pkt_in_if.end_of_packet, res)) begin
          if (pinned_valid) res = pinned_res;
          pending_results.push_back(res);
        end
      end
      if (out_acc) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          flag_mismatch("arrived with nothing pending, cause", res_out_if.error_cause, 0);
        end else begin
          want = pending_results.pop_front();
          if (res_out_if.header_ok !== want.header_ok)
            flag_mismatch("header_ok", res_out_if.header_ok, want.header_ok);
          if (res_out_if.error_cause !== want.cause)
            flag_mismatch("error_cause", res_out_if.error_cause, want.cause);
          if (res_out_if.payload_start !== want.start)
            flag_mismatch("payload_start", res_out_if.payload_start, want.start);
          if (res_out_if.payload_bytes !== want.bytes)
            flag_mismatch("payload_bytes", res_out_if.payload_bytes, want.bytes);
        end
      end
      if (in_acc || out_acc) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("%0t: no request moved for %0d cycles", $time, IDLE_LIMIT);
          $display("*** FAILED ***");
          $finish;
        end
      end
    end
  end

  initial begin
    pkt_in_if.valid = 1'b0;
    pkt_in_if.data_byte = '0;
    pkt_in_if.end_of_packet = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    foreach (directed_rows[i]) send_packet(directed_rows[i]);
    hold_until_drained();
    send_random_packets();
    hold_until_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/rtphp_pkg.sv
hw/rtl/rtphp_in_if.sv
hw/rtl/rtphp_out_if.sv
hw/rtl/rtphp_track.sv
hw/rtl/rtphp_check.sv
hw/rtl/rtp_header_payload_locator_top.sv
bench/rtp_header_payload_locator_top_tb.sv
